// ----- rtl/heading_cascade_pid_assert.svh -----
// ----------------------------------------------------------------------------
// heading_cascade_pid assertion macros
// Clocked assertion shorthands for the heading controller. They expect clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HEADING_CASCADE_PID_ASSERT_SVH
`define HEADING_CASCADE_PID_ASSERT_SVH

// The expression holds at every clock edge out of reset.
`define HCP_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define HCP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hcp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcp_pkg
// Types, constants and codes shared by the heading controller modules.
// ----------------------------------------------------------------------------
package hcp_pkg;

	localparam int OUTER_PERIOD = 20;
	localparam int INNER_PERIOD = 5;
	localparam int PHASE_W      = 5;

	localparam int MUL_A_W     = 32;
	localparam int MUL_B_W     = 26;
	localparam int PROD_W      = 58;
	localparam int ACC_W       = 36;
	localparam int MAG_W       = 28;
	localparam int RECIP_SHIFT = 28;

	typedef logic signed [15:0]        word_t;
	typedef logic signed [MUL_A_W-1:0] mul_a_t;
	typedef logic signed [MUL_B_W-1:0] mul_b_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [ACC_W:0]     drive_t;
	typedef logic [MAG_W-1:0]          mag_t;

	localparam logic [15:0] RST_TARGET_ANGLE  = 16'd0;
	localparam logic [15:0] RST_OUTER_KP      = 16'd32000;
	localparam logic [15:0] RST_OUTER_KI      = 16'd973;
	localparam logic [15:0] RST_INNER_KP      = 16'd579;
	localparam logic [15:0] RST_INNER_KD      = 16'd197;
	localparam logic [15:0] RST_BASE_DRIVE    = 16'd0;
	localparam logic [15:0] RST_DRIVE_FLOOR   = 16'hFC18;
	localparam logic [15:0] RST_DRIVE_CEILING = 16'd1000;

	localparam logic signed [16:0] HALF_TURN   = 17'sd18000;
	localparam logic signed [16:0] FULL_TURN   = 17'sd36000;
	localparam logic signed [16:0] ERR_BAND    = 17'sd500;
	localparam logic signed [17:0] INTEG_LIMIT = 18'sd100000;

	localparam mul_b_t COEF_NEW   = 26'sd7;
	localparam mul_b_t COEF_OLD   = 26'sd3;
	localparam mul_b_t RECIP_10   = 26'sd26843545;
	localparam mul_b_t RECIP_100  = 26'sd2684354;
	localparam mul_b_t DIVISOR_10 = 26'sd10;
	localparam mul_b_t DIVISOR_100 = 26'sd100;

	typedef enum logic [2:0] {
		REG_TARGET_ANGLE  = 3'd0,
		REG_OUTER_KP      = 3'd1,
		REG_OUTER_KI      = 3'd2,
		REG_INNER_KP      = 3'd3,
		REG_INNER_KD      = 3'd4,
		REG_BASE_DRIVE    = 3'd5,
		REG_DRIVE_FLOOR   = 3'd6,
		REG_DRIVE_CEILING = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SET
	} acc_op_t;

	typedef struct packed {
		logic    mul_en;
		acc_op_t acc_op;
	} mac_ctl_t;

	typedef enum logic [1:0] {
		DIV_TARGET,
		DIV_FILT,
		DIV_DERIV
	} div_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_O_ERR,
		S_O_WRAP,
		S_O_INT,
		S_O_M1,
		S_O_M2,
		S_O_ACC,
		S_D_MAG,
		S_D_RCP,
		S_D_BCK,
		S_D_FIX,
		S_I_F1,
		S_I_F2,
		S_I_FACC,
		S_I_D1,
		S_I_D2,
		S_I_D3,
		S_I_DACC,
		S_I_O1,
		S_I_O2,
		S_I_OUT
	} state_t;

endpackage

// ----- rtl/hcp_mac.sv -----
// ----------------------------------------------------------------------------
// hcp_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module hcp_mac (
	input  logic             clk,
	input  hcp_pkg::mac_ctl_t ctl,
	input  hcp_pkg::mul_a_t  a,
	input  hcp_pkg::mul_b_t  b,
	input  hcp_pkg::acc_t    set_val,
	output hcp_pkg::prod_t   prod,
	output hcp_pkg::acc_t    acc
);

	hcp_pkg::prod_t prod_q;
	hcp_pkg::acc_t  acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= a * b;
		end
		case (ctl.acc_op)
			hcp_pkg::ACC_LOAD: acc_q <= prod_q[hcp_pkg::ACC_W-1:0];
			hcp_pkg::ACC_ADD:  acc_q <= acc_q + $signed(prod_q[hcp_pkg::ACC_W-1:0]);
			hcp_pkg::ACC_SET:  acc_q <= set_val;
			default:           acc_q <= acc_q;
		endcase
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

// ----- rtl/heading_cascade_pid.sv -----
// An item on a tick with neither loop due is taken without leaving idle and gives no result.
// An inner-loop item keeps the block busy, with in_ready low, until its drive item is issued.
// An item that also runs the outer loop first updates the rate target, then runs the inner loop.
// Every step goes through the one shared multiply-accumulate unit, so its sequence sets the rate.
// Reset clears the loop state and phase and loads the register defaults.
// ----------------------------------------------------------------------------
// heading_cascade_pid
// Cascaded heading controller: an outer PI loop sets a yaw rate target and an
// inner PD loop turns it into saturated left and right motor drives.
// ----------------------------------------------------------------------------
`include "heading_cascade_pid_assert.svh"

module heading_cascade_pid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   yaw_angle,
	input  logic signed [15:0]   gyro_rate,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [15:0]   left_drive,
	output logic signed [15:0]   right_drive,
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);

	function automatic hcp_pkg::word_t clamp_drive(
		input hcp_pkg::drive_t v,
		input hcp_pkg::word_t  lo,
		input hcp_pkg::word_t  hi
	);
		hcp_pkg::drive_t t;
		t = v;
		if (t > hcp_pkg::drive_t'(hi)) begin
			t = hcp_pkg::drive_t'(hi);
		end
		if (t < hcp_pkg::drive_t'(lo)) begin
			t = hcp_pkg::drive_t'(lo);
		end
		return t[15:0];
	endfunction

	hcp_pkg::word_t target_angle_q;
	logic [15:0]    outer_kp_q;
	logic [15:0]    outer_ki_q;
	logic [15:0]    inner_kp_q;
	logic [15:0]    inner_kd_q;
	hcp_pkg::word_t base_drive_q;
	hcp_pkg::word_t drive_floor_q;
	hcp_pkg::word_t drive_ceiling_q;

	hcp_pkg::state_t   state_q;
	hcp_pkg::state_t   state_next;
	hcp_pkg::div_sel_t div_sel_q;
	logic [hcp_pkg::PHASE_W-1:0] tick_phase_q;
	logic [hcp_pkg::PHASE_W-1:0] inner_cnt_q;
	logic signed [17:0] integ_q;
	logic signed [31:0] rate_target_q;
	hcp_pkg::word_t     rate_filt_q;
	logic signed [31:0] deriv_q;
	logic               out_valid_q;

	hcp_pkg::word_t     yaw_q;
	hcp_pkg::word_t     gyro_q;
	logic signed [16:0] err_q;
	hcp_pkg::mag_t      mag_q;
	hcp_pkg::mag_t      quo_q;
	logic               neg_q;
	hcp_pkg::word_t     fnew_q;
	hcp_pkg::word_t     left_q;
	hcp_pkg::word_t     right_q;

	hcp_pkg::mac_ctl_t mac_ctl;
	hcp_pkg::mul_a_t   mul_a;
	hcp_pkg::mul_b_t   mul_b;
	hcp_pkg::acc_t     set_val;
	hcp_pkg::prod_t    prod;
	hcp_pkg::acc_t     acc;

	logic               accept;
	logic               slot_free;
	logic               emit;
	logic               err_in_turn;
	logic               err_in_band;
	logic signed [18:0] integ_sum;
	logic signed [17:0] integ_next;
	hcp_pkg::acc_t      acc_abs;
	hcp_pkg::mag_t      mag_next;
	hcp_pkg::mag_t      quo_est;
	hcp_pkg::mag_t      divisor;
	hcp_pkg::mag_t      rem;
	hcp_pkg::mag_t      quo_fix;
	logic signed [hcp_pkg::MAG_W:0] div_res;
	hcp_pkg::drive_t    left_wide;
	hcp_pkg::drive_t    right_wide;

	hcp_mac u_mac (
		.clk     (clk),
		.ctl     (mac_ctl),
		.a       (mul_a),
		.b       (mul_b),
		.set_val (set_val),
		.prod    (prod),
		.acc     (acc)
	);

	assign in_ready  = (state_q == hcp_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = (state_q == hcp_pkg::S_I_OUT) && slot_free;

	assign err_in_turn = (err_q <= hcp_pkg::HALF_TURN) && (err_q >= -hcp_pkg::HALF_TURN);
	assign err_in_band = (err_q < hcp_pkg::ERR_BAND) && (err_q > -hcp_pkg::ERR_BAND);

	always_comb begin
		integ_sum = 19'(integ_q);
		if (err_in_band) begin
			integ_sum = 19'(integ_q) + 19'(err_q);
		end
		if (integ_sum > 19'(hcp_pkg::INTEG_LIMIT)) begin
			integ_next = hcp_pkg::INTEG_LIMIT;
		end else if (integ_sum < -19'(hcp_pkg::INTEG_LIMIT)) begin
			integ_next = -hcp_pkg::INTEG_LIMIT;
		end else begin
			integ_next = integ_sum[17:0];
		end
	end

	assign acc_abs  = acc[hcp_pkg::ACC_W-1] ? -acc : acc;
	assign mag_next = (div_sel_q == hcp_pkg::DIV_TARGET) ? acc_abs[8 +: hcp_pkg::MAG_W]
		: acc_abs[hcp_pkg::MAG_W-1:0];
	assign quo_est  = prod[hcp_pkg::RECIP_SHIFT +: hcp_pkg::MAG_W];
	assign divisor  = (div_sel_q == hcp_pkg::DIV_TARGET) ? hcp_pkg::MAG_W'(hcp_pkg::DIVISOR_100)
		: hcp_pkg::MAG_W'(hcp_pkg::DIVISOR_10);
	assign rem      = mag_q - prod[hcp_pkg::MAG_W-1:0];
	assign quo_fix  = quo_q + hcp_pkg::MAG_W'(rem >= divisor);
	assign div_res  = neg_q ? -$signed({1'b0, quo_fix}) : $signed({1'b0, quo_fix});

	assign left_wide  = hcp_pkg::drive_t'(base_drive_q) - hcp_pkg::drive_t'(acc);
	assign right_wide = hcp_pkg::drive_t'(base_drive_q) + hcp_pkg::drive_t'(acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_angle_q  <= hcp_pkg::RST_TARGET_ANGLE;
			outer_kp_q      <= hcp_pkg::RST_OUTER_KP;
			outer_ki_q      <= hcp_pkg::RST_OUTER_KI;
			inner_kp_q      <= hcp_pkg::RST_INNER_KP;
			inner_kd_q      <= hcp_pkg::RST_INNER_KD;
			base_drive_q    <= hcp_pkg::RST_BASE_DRIVE;
			drive_floor_q   <= hcp_pkg::RST_DRIVE_FLOOR;
			drive_ceiling_q <= hcp_pkg::RST_DRIVE_CEILING;
		end else if (cfg_wr_en) begin
			case (hcp_pkg::reg_idx_t'(cfg_index))
				hcp_pkg::REG_TARGET_ANGLE:  target_angle_q  <= cfg_wdata;
				hcp_pkg::REG_OUTER_KP:      outer_kp_q      <= cfg_wdata;
				hcp_pkg::REG_OUTER_KI:      outer_ki_q      <= cfg_wdata;
				hcp_pkg::REG_INNER_KP:      inner_kp_q      <= cfg_wdata;
				hcp_pkg::REG_INNER_KD:      inner_kd_q      <= cfg_wdata;
				hcp_pkg::REG_BASE_DRIVE:    base_drive_q    <= cfg_wdata;
				hcp_pkg::REG_DRIVE_FLOOR:   drive_floor_q   <= cfg_wdata;
				hcp_pkg::REG_DRIVE_CEILING: drive_ceiling_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			hcp_pkg::S_IDLE: begin
				if (in_valid) begin
					if (tick_phase_q == '0) begin
						state_next = hcp_pkg::S_O_ERR;
					end else if (inner_cnt_q == '0) begin
						state_next = hcp_pkg::S_I_F1;
					end
				end
			end
			hcp_pkg::S_O_ERR:  state_next = hcp_pkg::S_O_WRAP;
			hcp_pkg::S_O_WRAP: begin
				if (err_in_turn) begin
					state_next = hcp_pkg::S_O_INT;
				end
			end
			hcp_pkg::S_O_INT:  state_next = hcp_pkg::S_O_M1;
			hcp_pkg::S_O_M1:   state_next = hcp_pkg::S_O_M2;
			hcp_pkg::S_O_M2:   state_next = hcp_pkg::S_O_ACC;
			hcp_pkg::S_O_ACC:  state_next = hcp_pkg::S_D_MAG;
			hcp_pkg::S_D_MAG:  state_next = hcp_pkg::S_D_RCP;
			hcp_pkg::S_D_RCP:  state_next = hcp_pkg::S_D_BCK;
			hcp_pkg::S_D_BCK:  state_next = hcp_pkg::S_D_FIX;
			hcp_pkg::S_D_FIX: begin
				case (div_sel_q)
					hcp_pkg::DIV_TARGET: state_next = hcp_pkg::S_I_F1;
					hcp_pkg::DIV_FILT:   state_next = hcp_pkg::S_I_D1;
					default:             state_next = hcp_pkg::S_I_O1;
				endcase
			end
			hcp_pkg::S_I_F1:   state_next = hcp_pkg::S_I_F2;
			hcp_pkg::S_I_F2:   state_next = hcp_pkg::S_I_FACC;
			hcp_pkg::S_I_FACC: state_next = hcp_pkg::S_D_MAG;
			hcp_pkg::S_I_D1:   state_next = hcp_pkg::S_I_D2;
			hcp_pkg::S_I_D2:   state_next = hcp_pkg::S_I_D3;
			hcp_pkg::S_I_D3:   state_next = hcp_pkg::S_I_DACC;
			hcp_pkg::S_I_DACC: state_next = hcp_pkg::S_D_MAG;
			hcp_pkg::S_I_O1:   state_next = hcp_pkg::S_I_O2;
			hcp_pkg::S_I_O2:   state_next = hcp_pkg::S_I_OUT;
			hcp_pkg::S_I_OUT: begin
				if (slot_free) begin
					state_next = hcp_pkg::S_IDLE;
				end
			end
			default:           state_next = hcp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mac_ctl.mul_en = 1'b0;
		mac_ctl.acc_op = hcp_pkg::ACC_HOLD;
		mul_a          = '0;
		mul_b          = '0;
		set_val        = $signed(prod[8 +: hcp_pkg::ACC_W]) + hcp_pkg::acc_t'(deriv_q);
		case (state_q)
			hcp_pkg::S_O_M1: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = hcp_pkg::mul_a_t'(err_q);
				mul_b          = $signed({10'b0, outer_kp_q});
			end
			hcp_pkg::S_O_M2: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = hcp_pkg::ACC_LOAD;
				mul_a          = hcp_pkg::mul_a_t'(integ_q);
				mul_b          = $signed({10'b0, outer_ki_q});
			end
			hcp_pkg::S_O_ACC, hcp_pkg::S_I_FACC, hcp_pkg::S_I_DACC: begin
				mac_ctl.acc_op = hcp_pkg::ACC_ADD;
			end
			hcp_pkg::S_D_RCP: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = $signed({4'b0, mag_q});
				mul_b          = (div_sel_q == hcp_pkg::DIV_TARGET) ? hcp_pkg::RECIP_100
					: hcp_pkg::RECIP_10;
			end
			hcp_pkg::S_D_BCK: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = $signed({4'b0, quo_est});
				mul_b          = (div_sel_q == hcp_pkg::DIV_TARGET) ? hcp_pkg::DIVISOR_100
					: hcp_pkg::DIVISOR_10;
			end
			hcp_pkg::S_I_F1: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = hcp_pkg::mul_a_t'(gyro_q);
				mul_b          = hcp_pkg::COEF_NEW;
			end
			hcp_pkg::S_I_F2: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = hcp_pkg::ACC_LOAD;
				mul_a          = hcp_pkg::mul_a_t'(rate_filt_q);
				mul_b          = hcp_pkg::COEF_OLD;
			end
			hcp_pkg::S_I_D1: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = hcp_pkg::mul_a_t'(rate_filt_q) - hcp_pkg::mul_a_t'(fnew_q);
				mul_b          = $signed({10'b0, inner_kd_q});
			end
			hcp_pkg::S_I_D2: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = $signed(prod[8 +: hcp_pkg::MUL_A_W]);
				mul_b          = hcp_pkg::COEF_NEW;
			end
			hcp_pkg::S_I_D3: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = hcp_pkg::ACC_LOAD;
				mul_a          = deriv_q;
				mul_b          = hcp_pkg::COEF_OLD;
			end
			hcp_pkg::S_I_O1: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = rate_target_q - hcp_pkg::mul_a_t'(fnew_q);
				mul_b          = $signed({10'b0, inner_kp_q});
			end
			hcp_pkg::S_I_O2: begin
				mac_ctl.acc_op = hcp_pkg::ACC_SET;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= hcp_pkg::S_IDLE;
			div_sel_q     <= hcp_pkg::DIV_TARGET;
			tick_phase_q  <= '0;
			inner_cnt_q   <= '0;
			integ_q       <= '0;
			rate_target_q <= '0;
			rate_filt_q   <= '0;
			deriv_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				if (tick_phase_q == hcp_pkg::PHASE_W'(hcp_pkg::OUTER_PERIOD - 1)) begin
					tick_phase_q <= '0;
					inner_cnt_q  <= '0;
				end else begin
					tick_phase_q <= tick_phase_q + 1'b1;
					if (inner_cnt_q == hcp_pkg::PHASE_W'(hcp_pkg::INNER_PERIOD - 1)) begin
						inner_cnt_q <= '0;
					end else begin
						inner_cnt_q <= inner_cnt_q + 1'b1;
					end
				end
			end
			case (state_q)
				hcp_pkg::S_O_INT:  integ_q   <= integ_next;
				hcp_pkg::S_O_ACC:  div_sel_q <= hcp_pkg::DIV_TARGET;
				hcp_pkg::S_I_FACC: div_sel_q <= hcp_pkg::DIV_FILT;
				hcp_pkg::S_I_DACC: div_sel_q <= hcp_pkg::DIV_DERIV;
				hcp_pkg::S_D_FIX: begin
					if (div_sel_q == hcp_pkg::DIV_TARGET) begin
						rate_target_q <= 32'(div_res);
					end else if (div_sel_q == hcp_pkg::DIV_DERIV) begin
						deriv_q     <= 32'(div_res);
						rate_filt_q <= fnew_q;
					end
				end
				default: ;
			endcase
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			yaw_q  <= yaw_angle;
			gyro_q <= gyro_rate;
		end
		case (state_q)
			hcp_pkg::S_O_ERR: begin
				err_q <= 17'(target_angle_q) - 17'(yaw_q);
			end
			hcp_pkg::S_O_WRAP: begin
				if (err_q > hcp_pkg::HALF_TURN) begin
					err_q <= err_q - hcp_pkg::FULL_TURN;
				end else if (err_q < -hcp_pkg::HALF_TURN) begin
					err_q <= err_q + hcp_pkg::FULL_TURN;
				end
			end
			hcp_pkg::S_D_MAG: begin
				neg_q <= acc[hcp_pkg::ACC_W-1];
				mag_q <= mag_next;
			end
			hcp_pkg::S_D_BCK: begin
				quo_q <= quo_est;
			end
			hcp_pkg::S_D_FIX: begin
				if (div_sel_q == hcp_pkg::DIV_FILT) begin
					fnew_q <= div_res[15:0];
				end
			end
			hcp_pkg::S_I_OUT: begin
				if (slot_free) begin
					left_q  <= clamp_drive(left_wide, drive_floor_q, drive_ceiling_q);
					right_q <= clamp_drive(right_wide, drive_floor_q, drive_ceiling_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;

	`HCP_ASSERT_ALWAYS(a_phase_range, tick_phase_q < hcp_pkg::PHASE_W'(hcp_pkg::OUTER_PERIOD), "tick phase out of range")
	`HCP_ASSERT_IMPLY(a_phase_align, tick_phase_q == '0, inner_cnt_q == '0, "inner phase not aligned at outer tick")
	`HCP_ASSERT_ALWAYS(a_integ_range, (integ_q <= hcp_pkg::INTEG_LIMIT) && (integ_q >= -hcp_pkg::INTEG_LIMIT), "integral outside clamp")
	`HCP_ASSERT_NEXT(a_idle_tick, accept && (tick_phase_q != '0) && (inner_cnt_q != '0), in_ready, "idle tick did not return to ready")

endmodule

// ----- sim/hcp_drive_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hcp_drive_checker
// Watches the tick, drive and register ports of the heading controller. It
// keeps its own copy of the loop state and registers, predicts the left and
// right drives for every tick that runs the inner loop, and compares each
// drive item with the oldest prediction.
// ----------------------------------------------------------------------------
module hcp_drive_checker
	import hcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  word_t       yaw_angle,
	input  word_t       gyro_rate,
	input  logic        out_valid,
	input  logic        out_ready,
	input  word_t       left_drive,
	input  word_t       right_drive,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	localparam int HALF_REV     = 18000;
	localparam int FULL_REV     = 36000;
	localparam int BAND         = 500;
	localparam int WINDUP_LIMIT = 100000;
	localparam int TARGET_SCALE = 25600;

	typedef struct {
		word_t left;
		word_t right;
	} drive_pair_t;

	drive_pair_t drives_due[$];
	drive_pair_t oldest;

	word_t       target_q, base_q, lo_q, hi_q;
	logic [15:0] okp_q, oki_q, ikp_q, ikd_q;

	int tick_phase;
	int heading_integral;
	int rate_goal;
	int rate_lp;
	int slope_lp;

	initial fail_count = 0;

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	function automatic word_t saturate_drive(input longint v);
		if (v > longint'(hi_q))
			v = hi_q;
		if (v < longint'(lo_q))
			v = lo_q;
		return word_t'(v);
	endfunction

	task automatic advance_tick(input word_t yaw, input word_t gyro);
		int          err;
		int          fresh;
		longint      mix;
		longint      slope;
		longint      steer;
		drive_pair_t p;
		if (tick_phase == 0) begin
			err = int'(target_q) - int'(yaw);
			while (err > HALF_REV)
				err -= FULL_REV;
			while (err < -HALF_REV)
				err += FULL_REV;
			if (err < BAND && err > -BAND)
				heading_integral += err;
			if (heading_integral > WINDUP_LIMIT)
				heading_integral = WINDUP_LIMIT;
			if (heading_integral < -WINDUP_LIMIT)
				heading_integral = -WINDUP_LIMIT;
			mix = longint'(okp_q) * err + longint'(oki_q) * heading_integral;
			rate_goal = int'(mix / TARGET_SCALE);
		end
		if (tick_phase % INNER_PERIOD == 0) begin
			fresh = (7 * int'(gyro) + 3 * rate_lp) / 10;
			slope = (longint'(ikd_q) * longint'(rate_lp - fresh)) >>> 8;
			slope_lp = int'((7 * slope + 3 * longint'(slope_lp)) / 10);
			rate_lp = fresh;
			steer = ((longint'(ikp_q) * (longint'(rate_goal) - fresh)) >>> 8) + slope_lp;
			p.left = saturate_drive(longint'(base_q) - steer);
			p.right = saturate_drive(longint'(base_q) + steer);
			drives_due.push_back(p);
		end
		tick_phase = (tick_phase + 1 >= OUTER_PERIOD) ? 0 : tick_phase + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drives_due.delete();
			target_q <= RST_TARGET_ANGLE;
			okp_q <= RST_OUTER_KP;
			oki_q <= RST_OUTER_KI;
			ikp_q <= RST_INNER_KP;
			ikd_q <= RST_INNER_KD;
			base_q <= RST_BASE_DRIVE;
			lo_q <= RST_DRIVE_FLOOR;
			hi_q <= RST_DRIVE_CEILING;
			tick_phase = 0;
			heading_integral = 0;
			rate_goal = 0;
			rate_lp = 0;
			slope_lp = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (drives_due.size() == 0) begin
					report_mismatch("drive item with none due, left_drive", left_drive, '0);
				end else begin
					oldest = drives_due.pop_front();
					if (left_drive !== oldest.left)
						report_mismatch("left_drive", left_drive, oldest.left);
					if (right_drive !== oldest.right)
						report_mismatch("right_drive", right_drive, oldest.right);
				end
			end
			if (in_valid && in_ready)
				advance_tick(yaw_angle, gyro_rate);
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_index))
					REG_TARGET_ANGLE:  target_q <= cfg_wdata;
					REG_OUTER_KP:      okp_q <= cfg_wdata;
					REG_OUTER_KI:      oki_q <= cfg_wdata;
					REG_INNER_KP:      ikp_q <= cfg_wdata;
					REG_INNER_KD:      ikd_q <= cfg_wdata;
					REG_BASE_DRIVE:    base_q <= cfg_wdata;
					REG_DRIVE_FLOOR:   lo_q <= cfg_wdata;
					REG_DRIVE_CEILING: hi_q <= cfg_wdata;
					default: ;
				endcase
			end
			pending <= drives_due.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives gyro ticks and register settings into the cascaded heading
// controller: a directed opening, preset extreme settings, then random
// phases, all but the last with bursty idling on both channels. The drive
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import hcp_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 500000;

	typedef struct {
		word_t       target;
		logic [15:0] okp;
		logic [15:0] oki;
		logic [15:0] ikp;
		logic [15:0] ikd;
		word_t       base;
		word_t       drive_lo;
		word_t       drive_hi;
	} ctrl_setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	word_t       yaw_angle = '0;
	word_t       gyro_rate = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	word_t       left_drive;
	word_t       right_drive;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	int            fail_count;
	int            pending;
	int            cycle_count = 0;
	int            stall_left = 0;
	bit            idling_on = 1'b0;
	int            lean;
	word_t         last_gyro = '0;
	ctrl_setting_t active_cfg;

	word_t dir_yaw [0:24] = '{499, 0, -1, 18000, -18000, 32767, -32768, 100, -500, 500,
		-499, 250, -250, 17999, -17999, 1, 0, 42, -42, 7, -32768, 300, -300, 12000, -12000};
	word_t dir_gyro [0:24] = '{32767, 0, 1, -1, 100, -32768, 32767, -32768, 0, 5,
		0, 200, -200, 1000, -1000, 32767, 32767, 0, 0, -7, -32768, 16384, -16384, 21845, -21846};

	always #5 clk = ~clk;

	heading_cascade_pid dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.yaw_angle(yaw_angle),
		.gyro_rate(gyro_rate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_drive(left_drive),
		.right_drive(right_drive),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	hcp_drive_checker u_drive_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.yaw_angle(yaw_angle),
		.gyro_rate(gyro_rate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_drive(left_drive),
		.right_drive(right_drive),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d drive items due", cycle_count, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The drive side stalls in random bursts while idling is on.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 9);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_tick(input word_t yaw, input word_t gyro);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		yaw_angle <= yaw;
		gyro_rate <= gyro;
		do @(posedge clk); while (!in_ready);
	endtask

	// Holds the tick side off until every drive item has come and the block
	// has had time to finish any outer-loop work.
	task automatic drain_drives();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic pick_tick(output word_t yaw, output word_t gyro);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			yaw = word_t'(int'(active_cfg.target) + int'($urandom_range(0, 1200)) - 600 + lean);
		else if (roll < 88)
			yaw = word_t'(int'($urandom_range(0, 36000)) - 18000);
		else
			yaw = word_t'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 50)
			gyro = word_t'(int'(last_gyro) + int'($urandom_range(0, 400)) - 200);
		else if (roll < 85)
			gyro = word_t'(int'($urandom_range(0, 4000)) - 2000);
		else
			gyro = word_t'($urandom);
		last_gyro = gyro;
	endtask

	task automatic run_phase(input ctrl_setting_t c, input int items, input bit idle);
		int    hold_at;
		word_t y;
		word_t g;
		drain_drives();
		put_reg(REG_TARGET_ANGLE, c.target);
		put_reg(REG_OUTER_KP, c.okp);
		put_reg(REG_OUTER_KI, c.oki);
		put_reg(REG_INNER_KP, c.ikp);
		put_reg(REG_INNER_KD, c.ikd);
		put_reg(REG_BASE_DRIVE, c.base);
		put_reg(REG_DRIVE_FLOOR, c.drive_lo);
		put_reg(REG_DRIVE_CEILING, c.drive_hi);
		cfg_wr_en <= 1'b0;
		active_cfg = c;
		idling_on <= idle;
		lean = $urandom_range(0, 1) ? 150 : -150;
		hold_at = $urandom_range(1, items - 1);
		for (int i = 0; i < items; i++) begin
			if (i == hold_at)
				drain_drives();
			pick_tick(y, g);
			send_tick(y, g);
		end
	endtask

	initial begin
		ctrl_setting_t c;
		int            span;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling_on <= 1'b1;

		for (int i = 0; i < 25; i++)
			send_tick(dir_yaw[i], dir_gyro[i]);

		// Floor above ceiling: every drive item should sit at the floor.
		c = '{target: 0, okp: RST_OUTER_KP, oki: RST_OUTER_KI, ikp: RST_INNER_KP,
			ikd: RST_INNER_KD, base: 0, drive_lo: 300, drive_hi: -300};
		run_phase(c, 40, 1'b1);
		c = '{target: 18000, okp: 16'hFFFF, oki: 16'hFFFF, ikp: 16'hFFFF, ikd: 16'hFFFF,
			base: 32767, drive_lo: -32768, drive_hi: 32767};
		run_phase(c, 40, 1'b1);
		c = '{target: -18000, okp: 0, oki: 0, ikp: 0, ikd: 0,
			base: -32768, drive_lo: -32768, drive_hi: 32767};
		run_phase(c, 40, 1'b0);
		c = '{target: -32768, okp: 16'hFFFF, oki: 1, ikp: 16'h8000, ikd: 16'h7FFF,
			base: 0, drive_lo: -32768, drive_hi: 32767};
		run_phase(c, 40, 1'b1);

		for (int p = 0; p < 7; p++) begin
			c.target = word_t'(int'($urandom_range(0, 36000)) - 18000);
			c.okp = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40000));
			c.oki = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4000));
			c.ikp = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4000));
			c.ikd = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(0, 4000));
			c.base = word_t'(int'($urandom_range(0, 4000)) - 2000);
			span = $urandom_range(0, 3000);
			c.drive_lo = word_t'(-span);
			c.drive_hi = word_t'($urandom_range(0, 3000));
			if ($urandom_range(0, 5) == 0) begin
				c.drive_lo = word_t'($urandom_range(0, 1000));
				c.drive_hi = word_t'(-span);
			end
			run_phase(c, 200, p != 6);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hcp_pkg.sv
rtl/hcp_mac.sv
rtl/heading_cascade_pid.sv
sim/hcp_drive_checker.sv
sim/tb_top.sv
